/* sv/tpg_pkg.sv */
// Shared types, constants and codes for the trapezoidal profile generator.
package tpg_pkg;

  localparam int INDEX_BITS = 16;
  localparam int LEN_W      = 16;
  localparam int CMP_W      = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 5;

  localparam int DIV_W             = 64;
  localparam int DEN_W             = LEN_W + 1;
  localparam int DIV_BITS_PER_CYC  = 2;
  localparam int DIV_CYCLES        = DIV_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W         = $clog2(DIV_CYCLES);

  typedef enum logic [2:0] {
    RA_START_POS = 3'd0,
    RA_END_POS   = 3'd1,
    RA_PEAK_VEL  = 3'd2,
    RA_ACCEL_N   = 3'd3,
    RA_DECEL_N   = 3'd4,
    RA_TOTAL_N   = 3'd5
  } reg_addr_t;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MUL_POS,
    ST_HALF,
    ST_START_POS,
    ST_WAIT_POS,
    ST_MUL_VEL,
    ST_START_VEL,
    ST_WAIT_VEL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start_position;
    logic signed [DATA_W-1:0] end_position;
    logic signed [DATA_W-1:0] peak_velocity;
    logic [LEN_W-1:0]         accel_samples;
    logic [LEN_W-1:0]         decel_samples;
    logic [LEN_W-1:0]         total_samples;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic square;
    logic mul_pos;
    logic half;
    logic div_pos;
    logic take_pos;
    logic mul_vel;
    logic div_vel;
    logic take_vel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cruise;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

/* sv/tpg_if.sv */
// Stream channel interfaces: tick input and sample output.
interface tpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface tpg_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       position;
  logic signed [31:0]       velocity;
  logic [1:0]               phase;
  logic                     last;

  modport source (output valid, output position, output velocity, output phase,
                  output last, input ready);
  modport sink   (input valid, input position, input velocity, input phase,
                  input last, output ready);
endinterface

/* sv/trapezoidal_profile_generator.sv */
// Top level of the trapezoidal profile generator.
//
//  channel  role    handshake        payload
//  tick     sink    valid / ready    restart
//  sample   source  valid / ready    position, velocity, phase, last
//  apb      slave   psel / penable   paddr, pwdata, prdata (pready tied high)
//
// One item at a time. Acceleration and deceleration samples are loaded into the output
// register after square and multiply steps plus two passes through the 2-bit-per-cycle
// divider, each pass followed by a step that picks up the quotient.
// Cruise samples are loaded after the square, multiply and halving steps (no division).
// The next tick is taken the cycle after the load.
// Reset clears the sample index and the registers to their defaults; a stalled sample
// output holds the sequencer in its final step until the output register frees up.
module trapezoidal_profile_generator (
  input  logic                          clk,
  input  logic                          rst,
  tpg_in_if.sink                        tick,
  tpg_out_if.source                     sample,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpg_pkg::PADDR_W-1:0]   paddr,
  input  logic [tpg_pkg::DATA_W-1:0]    pwdata,
  output logic [tpg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  tpg_pkg::cfg_t    cfg;
  tpg_pkg::cmd_t    cmd;
  tpg_pkg::status_t status;

  tpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .status     (status),
    .cmd        (cmd)
  );

  tpg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .restart   (tick.restart),
    .out_valid (sample.valid),
    .out_ready (sample.ready),
    .position  (sample.position),
    .velocity  (sample.velocity),
    .out_phase (sample.phase),
    .out_last  (sample.last)
  );

endmodule

/* sv/tpg_regs.sv */
// APB configuration register file.
module tpg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpg_pkg::PADDR_W-1:0]   paddr,
  input  logic [tpg_pkg::DATA_W-1:0]    pwdata,
  output logic [tpg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output tpg_pkg::cfg_t                 cfg
);

  tpg_pkg::reg_addr_t addr;
  logic               wr_en;

  assign addr   = tpg_pkg::reg_addr_t'(paddr[tpg_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_position <= '0;
      cfg.end_position   <= '0;
      cfg.peak_velocity  <= '0;
      cfg.accel_samples  <= tpg_pkg::LEN_W'(1);
      cfg.decel_samples  <= tpg_pkg::LEN_W'(1);
      cfg.total_samples  <= tpg_pkg::LEN_W'(2);
    end else if (wr_en) begin
      unique case (addr)
        tpg_pkg::RA_START_POS: cfg.start_position <= pwdata;
        tpg_pkg::RA_END_POS:   cfg.end_position   <= pwdata;
        tpg_pkg::RA_PEAK_VEL:  cfg.peak_velocity  <= pwdata;
        tpg_pkg::RA_ACCEL_N:   cfg.accel_samples  <= pwdata[tpg_pkg::LEN_W-1:0];
        tpg_pkg::RA_DECEL_N:   cfg.decel_samples  <= pwdata[tpg_pkg::LEN_W-1:0];
        tpg_pkg::RA_TOTAL_N:   cfg.total_samples  <= pwdata[tpg_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      tpg_pkg::RA_START_POS: prdata = cfg.start_position;
      tpg_pkg::RA_END_POS:   prdata = cfg.end_position;
      tpg_pkg::RA_PEAK_VEL:  prdata = cfg.peak_velocity;
      tpg_pkg::RA_ACCEL_N:   prdata = tpg_pkg::DATA_W'(cfg.accel_samples);
      tpg_pkg::RA_DECEL_N:   prdata = tpg_pkg::DATA_W'(cfg.decel_samples);
      tpg_pkg::RA_TOTAL_N:   prdata = tpg_pkg::DATA_W'(cfg.total_samples);
      default:               prdata = '0;
    endcase
  end

endmodule

/* sv/tpg_div.sv */
// Restoring unsigned divider, two quotient bits per cycle.
module tpg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpg_pkg::DIV_W-1:0]     dividend,
  input  logic [tpg_pkg::DEN_W-1:0]     divisor,
  output logic                          done,
  output logic [tpg_pkg::DIV_W-1:0]     quotient
);

  logic                              busy;
  logic [tpg_pkg::DIV_CNT_W-1:0]     count;
  logic [tpg_pkg::DEN_W-1:0]         dvs;
  logic [tpg_pkg::DEN_W-1:0]         rem;
  logic [tpg_pkg::DEN_W-1:0]         rem_next;
  logic [tpg_pkg::DIV_W-1:0]         quotient_next;
  logic [tpg_pkg::DEN_W:0]           trial;
  logic                              qbit;

  // Shift the dividend through the remainder; quotient bits fill from the bottom.
  always_comb begin
    rem_next      = rem;
    quotient_next = quotient;
    trial         = '0;
    qbit          = 1'b0;
    for (int i = 0; i < tpg_pkg::DIV_BITS_PER_CYC; i++) begin
      trial = {rem_next, quotient_next[tpg_pkg::DIV_W-1]};
      if (trial >= {1'b0, dvs}) begin
        rem_next = tpg_pkg::DEN_W'(trial - {1'b0, dvs});
        qbit     = 1'b1;
      end else begin
        rem_next = trial[tpg_pkg::DEN_W-1:0];
        qbit     = 1'b0;
      end
      quotient_next = {quotient_next[tpg_pkg::DIV_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == tpg_pkg::DIV_CNT_W'(tpg_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= quotient_next;
      rem      <= rem_next;
    end
  end

endmodule

/* sv/tpg_ctrl.sv */
// Sequencing state machine for one sample computation.
module tpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_ready,
  input  tpg_pkg::status_t   status,
  output tpg_pkg::cmd_t      cmd
);

  tpg_pkg::state_t state;
  tpg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    tick_ready = 1'b0;
    unique case (state)
      tpg_pkg::ST_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.load   = 1'b1;
          state_next = tpg_pkg::ST_SQUARE;
        end
      end
      tpg_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = tpg_pkg::ST_MUL_POS;
      end
      tpg_pkg::ST_MUL_POS: begin
        cmd.mul_pos = 1'b1;
        state_next  = status.cruise ? tpg_pkg::ST_HALF : tpg_pkg::ST_START_POS;
      end
      tpg_pkg::ST_HALF: begin
        cmd.half   = 1'b1;
        state_next = tpg_pkg::ST_FINISH;
      end
      tpg_pkg::ST_START_POS: begin
        cmd.div_pos = 1'b1;
        state_next  = tpg_pkg::ST_WAIT_POS;
      end
      tpg_pkg::ST_WAIT_POS: begin
        if (status.div_done) begin
          cmd.take_pos = 1'b1;
          state_next   = tpg_pkg::ST_MUL_VEL;
        end
      end
      tpg_pkg::ST_MUL_VEL: begin
        cmd.mul_vel = 1'b1;
        state_next  = tpg_pkg::ST_START_VEL;
      end
      tpg_pkg::ST_START_VEL: begin
        cmd.div_vel = 1'b1;
        state_next  = tpg_pkg::ST_WAIT_VEL;
      end
      tpg_pkg::ST_WAIT_VEL: begin
        if (status.div_done) begin
          cmd.take_vel = 1'b1;
          state_next   = tpg_pkg::ST_FINISH;
        end
      end
      tpg_pkg::ST_FINISH: begin
        // hold the finished sample until the output register frees up
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = tpg_pkg::ST_IDLE;
        end
      end
      default: state_next = tpg_pkg::ST_IDLE;
    endcase
  end

endmodule

/* sv/tpg_dp.sv */
// Datapath: sample index, shared multiplier, divider and output register.
module tpg_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  tpg_pkg::cmd_t                   cmd,
  output tpg_pkg::status_t                status,
  input  tpg_pkg::cfg_t                   cfg,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              position,
  output logic signed [31:0]              velocity,
  output logic [1:0]                      out_phase,
  output logic                            out_last
);

  localparam int SUM_W  = tpg_pkg::DIV_W + 2;
  localparam int QPOS_W = 48;
  localparam logic [tpg_pkg::CMP_W-1:0] KMAX =
    tpg_pkg::CMP_W'((64'd1 << tpg_pkg::INDEX_BITS) - 64'd1);

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'sh7FFF_FFFF);
    lo = SUM_W'(32'sh8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  logic [tpg_pkg::INDEX_BITS-1:0]  sample_index;
  tpg_pkg::phase_t                 phase;
  logic                            last;
  logic [tpg_pkg::LEN_W-1:0]       lin;
  logic [tpg_pkg::DEN_W-1:0]       dmul;
  logic [tpg_pkg::LEN_W-1:0]       den;
  logic [31:0]                     sq;
  logic [63:0]                     prod;
  logic [QPOS_W-1:0]               qpos;
  logic [31:0]                     qvel;

  // index selection on transfer
  logic [tpg_pkg::CMP_W-1:0]       k_ext;
  logic [tpg_pkg::CMP_W-1:0]       nf_ext;
  logic [tpg_pkg::LEN_W-1:0]       k_eff;
  logic signed [tpg_pkg::LEN_W+1:0] cruise_lim;
  tpg_pkg::phase_t                 phase_next;

  always_comb begin
    nf_ext = tpg_pkg::CMP_W'(cfg.total_samples);
    k_ext  = restart ? '0 : tpg_pkg::CMP_W'(sample_index);
    if (k_ext > nf_ext) begin
      k_ext = nf_ext;
    end
    k_eff      = k_ext[tpg_pkg::LEN_W-1:0];
    cruise_lim = $signed({2'b00, cfg.total_samples}) - $signed({2'b00, cfg.decel_samples});
    if (k_eff < cfg.accel_samples) begin
      phase_next = tpg_pkg::PH_ACCEL;
    end else if ($signed({2'b00, k_eff}) <= cruise_lim) begin
      phase_next = tpg_pkg::PH_CRUISE;
    end else begin
      phase_next = tpg_pkg::PH_DECEL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (cmd.load) begin
      // advance, stopping at the end of the trajectory or at the top of the index range
      if (k_ext < nf_ext && k_ext < KMAX) begin
        sample_index <= k_ext[tpg_pkg::INDEX_BITS-1:0] + 1'b1;
      end else begin
        sample_index <= k_ext[tpg_pkg::INDEX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      phase <= phase_next;
      last  <= (k_ext == nf_ext);
      dmul  <= tpg_pkg::DEN_W'({k_eff, 1'b0} - {1'b0, cfg.accel_samples});
      if (phase_next == tpg_pkg::PH_ACCEL) begin
        lin <= k_eff;
        den <= cfg.accel_samples;
      end else begin
        lin <= cfg.total_samples - k_eff;
        den <= cfg.decel_samples;
      end
    end
  end

  // shared multiplier: |v| times one factor per step
  logic        v_neg;
  logic [31:0] v_mag;
  logic [31:0] mul_b;

  assign v_neg = cfg.peak_velocity[31];
  assign v_mag = v_neg ? 32'(-cfg.peak_velocity) : 32'(cfg.peak_velocity);

  always_comb begin
    if (cmd.mul_vel) begin
      mul_b = 32'(lin);
    end else if (phase == tpg_pkg::PH_CRUISE) begin
      mul_b = 32'(dmul);
    end else begin
      mul_b = sq;
    end
  end

  logic [63:0] prod_round;
  assign prod_round = prod + 64'd1;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq <= 32'(lin) * 32'(lin);
    end
    if (cmd.mul_pos || cmd.mul_vel) begin
      prod <= 64'(v_mag) * 64'(mul_b);
    end
  end

  // rounding bias is half the divisor
  logic                        div_done;
  logic [tpg_pkg::DIV_W-1:0]   quotient;
  logic [tpg_pkg::DIV_W-1:0]   dividend;
  logic [tpg_pkg::DEN_W-1:0]   divisor;

  always_comb begin
    if (cmd.div_vel) begin
      dividend = prod + tpg_pkg::DIV_W'(den[tpg_pkg::LEN_W-1:1]);
      divisor  = {1'b0, den};
    end else begin
      dividend = prod + tpg_pkg::DIV_W'(den);
      divisor  = {den, 1'b0};
    end
  end

  tpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_pos || cmd.div_vel),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.half) begin
      qpos <= prod_round[QPOS_W:1];
    end else if (cmd.take_pos) begin
      qpos <= quotient[QPOS_W-1:0];
    end
    if (cmd.take_vel) begin
      qvel <= quotient[31:0];
    end
  end

  // final sums
  logic                    pos_neg;
  logic signed [SUM_W-1:0] pos_base;
  logic signed [SUM_W-1:0] pos_term;
  logic signed [SUM_W-1:0] pos_sum;
  logic signed [SUM_W-1:0] vel_term;

  always_comb begin
    pos_neg  = v_neg ^ (phase == tpg_pkg::PH_DECEL);
    pos_base = (phase == tpg_pkg::PH_DECEL) ? SUM_W'(cfg.end_position)
                                            : SUM_W'(cfg.start_position);
    pos_term = $signed(SUM_W'(qpos));
    pos_sum  = pos_neg ? pos_base - pos_term : pos_base + pos_term;
    if (phase == tpg_pkg::PH_CRUISE) begin
      vel_term = SUM_W'(cfg.peak_velocity);
    end else if (v_neg) begin
      vel_term = -$signed(SUM_W'(qvel));
    end else begin
      vel_term = $signed(SUM_W'(qvel));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      position  <= sat32(pos_sum);
      velocity  <= sat32(vel_term);
      out_phase <= phase;
      out_last  <= last;
    end
  end

  assign status.cruise   = (phase == tpg_pkg::PH_CRUISE);
  assign status.div_done = div_done;
  assign status.out_busy = out_valid && !out_ready;

endmodule
